// ----- rtl/assert_macros.svh -----
// Assertion macros used by the field extractor top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds in the same cycle as its antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a property holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dnsfx_pkg.sv -----
// Package with the types, codes and constants of the DNS response field extractor.
`default_nettype none

package dnsfx_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgPayloadOffset = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxQuestions = 2'd1;

  localparam logic [3:0] HdrLastIdx = 4'd11;
  localparam logic [3:0] QFixedLastIdx = 4'd3;
  localparam logic [3:0] AnsLastIdx = 4'd11;
  localparam logic [7:0] PtrMark = 8'hc0;
  localparam logic [7:0] DotChar = 8'd46;
  localparam logic [15:0] TypeA = 16'd1;
  localparam logic [15:0] TypeAaaa = 16'd28;
  localparam logic [15:0] TypeCname = 16'd5;
  localparam logic [15:0] Addr4Len = 16'd4;
  localparam logic [15:0] Addr6Len = 16'd16;
  localparam logic [8:0] PosMax = 9'd256;
  localparam logic [7:0] OffsetReset = 8'd42;
  localparam logic [15:0] MaxQuestionsReset = 16'd1;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'd0,
    PH_HEADER = 3'd1,
    PH_QNAME  = 3'd2,
    PH_QFIXED = 3'd3,
    PH_ANSWER = 3'd4,
    PH_RDATA  = 3'd5,
    PH_DONE   = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    RK_HEADER      = 3'd0,
    RK_NAME_CHAR   = 3'd1,
    RK_QUESTION    = 3'd2,
    RK_ANSWER      = 3'd3,
    RK_DISCARDED   = 3'd4,
    RK_UNSUPPORTED = 3'd5,
    RK_FRAME_END   = 3'd6
  } res_kind_e;

  typedef enum logic [1:0] {
    REC_IPV4  = 2'd0,
    REC_IPV6  = 2'd1,
    REC_CNAME = 2'd2,
    REC_OTHER = 2'd3
  } rec_kind_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [7:0]  name_char;
    logic [31:0] time_to_live;
    logic [1:0]  record_kind;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic        packet_last;
  } out_item_t;

  function automatic rec_kind_e kind_of(input logic [15:0] rtype);
    rec_kind_e k;
    if (rtype == TypeA) k = REC_IPV4;
    else if (rtype == TypeAaaa) k = REC_IPV6;
    else if (rtype == TypeCname) k = REC_CNAME;
    else k = REC_OTHER;
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dns_response_field_extractor.sv -----
// Top level of the DNS response field extractor: byte parser and output skid stage.
// The block takes a captured frame one byte per input transaction on the in
// channel (in_valid_i, in_stall_o, in_item_i) and returns zero or one result per
// byte on the out channel (out_valid_o, out_stall_i, out_item_o).
// Each accepted byte updates the parser state registers; its result, if any, is
// registered in out_q, or in skid_q while the receiver stalls. A byte can be
// accepted every cycle while the skid register is empty: one byte per cycle.
// The byte with frame_end set always yields a result with packet_last set, and
// the parser then returns to its reset state for the next frame.
// The configuration port (cfg_we_i, cfg_index_i, cfg_wdata_i) sets the header
// length skipped before the DNS message and the largest question count allowed.
// Reset clears the parser and the valid flags of both output registers and loads
// the register defaults: a 42-byte offset and a limit of one question.
// When the receiver stalls, the pending result is held and one more result is
// kept in a skid register; in_stall_o rises only while that skid register is full.
`default_nettype none

`include "assert_macros.svh"

module dns_response_field_extractor import dnsfx_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_item_t            in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_item_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  logic [7:0]  offset_q;
  logic [15:0] max_q_q;

  phase_e      phase_q, phase_d;
  logic [8:0]  pos_q, pos_d;
  logic [7:0]  label_rem_q, label_rem_d;
  logic        label_seen_q, label_seen_d;
  logic [3:0]  fidx_q, fidx_d;
  logic [15:0] trans_q, trans_d;
  logic [15:0] qs_q, qs_d;
  logic [15:0] ans_q, ans_d;
  logic [15:0] type_q, type_d;
  logic [15:0] class_q, class_d;
  logic [31:0] ttl_q, ttl_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] total_q, total_d;
  logic [63:0] up_q, up_d;
  logic [63:0] lo_q, lo_d;

  out_item_t   out_q, skid_q, res;
  logic        out_valid_q, skid_valid_q;
  logic        got, do_finish, in_accept, out_ready;
  phase_e      eff_phase;
  logic [3:0]  eff_fidx, fidx_inc;
  logic [15:0] rd_idx;
  logic [7:0]  b;

  assign b = in_item_i.frame_byte;
  assign in_accept = in_valid_i && !skid_valid_q;
  assign out_ready = !out_valid_q || !out_stall_i;
  assign in_stall_o = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;
  assign rd_idx = total_q - rem_q;

  always_comb begin
    label_rem_d = label_rem_q;
    label_seen_d = label_seen_q;
    trans_d = trans_q;
    qs_d = qs_q;
    ans_d = ans_q;
    type_d = type_q;
    class_d = class_q;
    ttl_d = ttl_q;
    rem_d = rem_q;
    total_d = total_q;
    up_d = up_q;
    lo_d = lo_q;
    got = 1'b0;
    do_finish = 1'b0;
    res = '0;
    eff_phase = phase_q;
    eff_fidx = fidx_q;
    if (phase_q == PH_SKIP && pos_q >= {1'b0, offset_q}) begin
      eff_phase = PH_HEADER;
      eff_fidx = '0;
    end
    phase_d = eff_phase;
    fidx_d = eff_fidx;
    fidx_inc = eff_fidx + 4'd1;

    unique case (eff_phase)
      PH_SKIP: begin
      end
      PH_HEADER: begin
        if (eff_fidx < 4'd2) begin
          trans_d = {trans_q[7:0], b};
        end else if (eff_fidx == 4'd4 || eff_fidx == 4'd5) begin
          qs_d = {qs_q[7:0], b};
        end else if (eff_fidx == 4'd6 || eff_fidx == 4'd7) begin
          ans_d = {ans_q[7:0], b};
        end
        fidx_d = fidx_inc;
        if (eff_fidx == HdrLastIdx) begin
          got = 1'b1;
          res.word_a = trans_d;
          res.word_b = qs_d;
          res.word_c = ans_d;
          fidx_d = '0;
          if (qs_d > max_q_q) begin
            res.result_kind = RK_DISCARDED;
            phase_d = PH_DONE;
          end else begin
            res.result_kind = RK_HEADER;
            label_rem_d = '0;
            label_seen_d = 1'b0;
            phase_d = PH_QNAME;
          end
        end
      end
      PH_QNAME: begin
        if (label_rem_q != '0) begin
          label_rem_d = label_rem_q - 8'd1;
          got = 1'b1;
          res.result_kind = RK_NAME_CHAR;
          res.name_char = b;
        end else if (b == '0) begin
          fidx_d = '0;
          phase_d = PH_QFIXED;
        end else begin
          label_rem_d = b;
          if (label_seen_q) begin
            got = 1'b1;
            res.result_kind = RK_NAME_CHAR;
            res.name_char = DotChar;
          end
          label_seen_d = 1'b1;
        end
      end
      PH_QFIXED: begin
        if (eff_fidx < 4'd2) type_d = {type_q[7:0], b};
        else class_d = {class_q[7:0], b};
        fidx_d = fidx_inc;
        if (eff_fidx == QFixedLastIdx) begin
          got = 1'b1;
          res.result_kind = RK_QUESTION;
          res.word_a = type_d;
          res.word_b = class_d;
          fidx_d = '0;
          phase_d = (ans_q == '0) ? PH_DONE : PH_ANSWER;
        end
      end
      PH_ANSWER: begin
        if (eff_fidx == '0 && b != PtrMark) begin
          got = 1'b1;
          res.result_kind = RK_UNSUPPORTED;
          phase_d = PH_DONE;
        end else begin
          if (eff_fidx == 4'd2 || eff_fidx == 4'd3) begin
            type_d = {type_q[7:0], b};
          end else if (eff_fidx == 4'd4 || eff_fidx == 4'd5) begin
            class_d = {class_q[7:0], b};
          end else if (eff_fidx >= 4'd6 && eff_fidx < 4'd10) begin
            ttl_d = {ttl_q[23:0], b};
          end else if (eff_fidx >= 4'd10) begin
            total_d = {total_q[7:0], b};
          end
          fidx_d = fidx_inc;
          if (eff_fidx == AnsLastIdx) begin
            rem_d = total_d;
            up_d = '0;
            lo_d = '0;
            if (total_d == '0) do_finish = 1'b1;
            else phase_d = PH_RDATA;
          end
        end
      end
      PH_RDATA: begin
        if ((type_q == TypeA && rd_idx < Addr4Len) ||
            (type_q == TypeAaaa && rd_idx < Addr6Len)) begin
          up_d = {up_q[55:0], lo_q[63:56]};
          lo_d = {lo_q[55:0], b};
        end
        rem_d = rem_q - 16'd1;
        if (rem_d == '0) do_finish = 1'b1;
      end
      default: begin
      end
    endcase

    if (do_finish) begin
      got = 1'b1;
      res.result_kind = RK_ANSWER;
      res.word_a = type_d;
      res.word_b = class_d;
      res.word_c = total_d;
      res.time_to_live = ttl_d;
      res.record_kind = kind_of(type_d);
      res.address_high = up_d;
      res.address_low = lo_d;
      ans_d = ans_q - 16'd1;
      fidx_d = '0;
      phase_d = (ans_d == '0) ? PH_DONE : PH_ANSWER;
    end

    pos_d = (pos_q == PosMax) ? pos_q : pos_q + 9'd1;

    if (in_item_i.frame_end) begin
      if (!got) begin
        res = '0;
        res.result_kind = RK_FRAME_END;
      end
      res.packet_last = 1'b1;
      got = 1'b1;
      phase_d = PH_SKIP;
      pos_d = '0;
      label_rem_d = '0;
      label_seen_d = 1'b0;
      fidx_d = '0;
      trans_d = '0;
      qs_d = '0;
      ans_d = '0;
      type_d = '0;
      class_d = '0;
      ttl_d = '0;
      rem_d = '0;
      total_d = '0;
      up_d = '0;
      lo_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OffsetReset;
      max_q_q <= MaxQuestionsReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgPayloadOffset) offset_q <= cfg_wdata_i[7:0];
      else if (cfg_index_i == CfgMaxQuestions) max_q_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      pos_q <= '0;
      label_rem_q <= '0;
      label_seen_q <= 1'b0;
      fidx_q <= '0;
      trans_q <= '0;
      qs_q <= '0;
      ans_q <= '0;
      type_q <= '0;
      class_q <= '0;
      ttl_q <= '0;
      rem_q <= '0;
      total_q <= '0;
      up_q <= '0;
      lo_q <= '0;
    end else if (in_accept) begin
      phase_q <= phase_d;
      pos_q <= pos_d;
      label_rem_q <= label_rem_d;
      label_seen_q <= label_seen_d;
      fidx_q <= fidx_d;
      trans_q <= trans_d;
      qs_q <= qs_d;
      ans_q <= ans_d;
      type_q <= type_d;
      class_q <= class_d;
      ttl_q <= ttl_d;
      rem_q <= rem_d;
      total_q <= total_d;
      up_q <= up_d;
      lo_q <= lo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready) begin
      if (skid_valid_q) begin
        out_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_accept && got;
      end
    end else if (in_accept && got) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (in_accept && got) out_q <= res;
    end else if (in_accept && got) begin
      skid_q <= res;
    end
  end

  `ASSERT_SAME(a_skid_implies_out, skid_valid_q, out_valid_q, "Skid register full while output is empty.")
  `ASSERT_SAME(a_rdata_nonzero, phase_q == PH_RDATA, rem_q != '0, "Rdata phase with nothing left to skip.")
  `ASSERT_SAME(a_skip_index_clear, phase_q == PH_SKIP, fidx_q == '0, "Field index not clear while skipping headers.")
  `ASSERT_NEXT(a_frame_end_result, in_accept && in_item_i.frame_end && out_ready && !skid_valid_q,
               out_valid_o && out_item_o.packet_last, "Frame end transaction produced no last result.")

endmodule

`default_nettype wire
